// ===== rtl/sb2dec_pkg.sv =====
// Package: shared types, constants and the BCD adjust function for the decimal text converter.
package sb2dec_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned NumDigits = 19;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);
  localparam int unsigned CharW     = 8;

  localparam logic [CharW-1:0] CharZero  = 8'd48;
  localparam logic [CharW-1:0] CharMinus = 8'd45;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic shift_dig;
    logic emit_sign;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic one_left;
    logic neg;
  } sts_t;

  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] bcd);
    logic [BcdW-1:0] res;
    res = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/sb2dec_dp.sv =====
// Datapath: magnitude, shift-add-3 BCD register, digit counter and character output.
module sb2dec_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sb2dec_pkg::cmd_t                  cmd_i,
  output sb2dec_pkg::sts_t                  sts_o,
  input  logic [sb2dec_pkg::ValueW-1:0]     value_i,
  output logic [sb2dec_pkg::CharW-1:0]      char_code_o,
  output logic                              last_char_o
);
  import sb2dec_pkg::*;

  logic [ValueW-1:0]  mag_q, mag_d;
  logic [BcdW-1:0]    bcd_q, bcd_d, bcd_adj;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic               neg_q, neg_d;

  assign bcd_adj = bcd_adjust(bcd_q);

  always_comb begin
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    neg_d     = neg_q;
    if (cmd_i.load) begin
      neg_d     = value_i[ValueW-1];
      mag_d     = value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;
      bcd_d     = '0;
      bit_cnt_d = '0;
      dig_cnt_d = DigCntW'(NumDigits);
    end else if (cmd_i.conv) begin
      bcd_d     = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
      mag_d     = {mag_q[ValueW-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q + BitCntW'(1);
    end else if (cmd_i.shift_dig) begin
      bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
      dig_cnt_d = dig_cnt_q - DigCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
      neg_q     <= 1'b0;
    end else begin
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
      neg_q     <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign sts_o.conv_last = (bit_cnt_q == BitCntW'(ValueW - 1));
  assign sts_o.top_zero  = (bcd_q[BcdW-1 -: 4] == 4'd0);
  assign sts_o.one_left  = (dig_cnt_q == DigCntW'(1));
  assign sts_o.neg       = neg_q;

  assign char_code_o = cmd_i.emit_sign ? CharMinus : (CharZero + {4'd0, bcd_q[BcdW-1 -: 4]});
  assign last_char_o = !cmd_i.emit_sign && sts_o.one_left;

endmodule

// ===== rtl/sb2dec_ctrl.sv =====
// Controller: state machine that sequences load, conversion, zero skip and character output.
module sb2dec_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             valid_o,
  output sb2dec_pkg::cmd_t cmd_o,
  input  sb2dec_pkg::sts_t sts_i
);
  import sb2dec_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    valid_o = 1'b0;
    busy    = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_last) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (sts_i.top_zero && !sts_i.one_left) begin
          cmd_o.shift_dig = 1'b1;
        end else begin
          state_d = sts_i.neg ? StSign : StEmit;
        end
      end
      StSign: begin
        valid_o         = 1'b1;
        cmd_o.emit_sign = 1'b1;
        state_d         = StEmit;
      end
      StEmit: begin
        valid_o         = 1'b1;
        cmd_o.shift_dig = 1'b1;
        if (sts_i.one_left) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == StConv))
    else $error("accepted transaction did not enter conversion");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && sts_i.one_left) |=> (state_q == StIdle))
    else $error("controller did not return to idle after last character");

  a_sign_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSign) |=> (state_q == StEmit && valid_o))
    else $error("sign not followed by a digit");

  a_conv_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv && sts_i.conv_last) |=> (state_q == StSkip))
    else $error("conversion did not end after the last bit");

endmodule

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// Top level: signed 64-bit integer to decimal ASCII character stream.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  input    | start / busy          | value_i[63:0] (signed)
//  result   | valid_o strobe        | char_code_o[7:0], last_char_o
//
// A transaction is taken when start is high and busy is low; that cycle loads the value.
// Each value is shifted bit by bit into the 19-digit BCD register with shift-add-3, then
// the controller settles on the first digit, skipping leading zero digits but keeping at
// least the last one, and emits the digits one each, preceded by '-' when negative.
// Reset is asynchronous and returns the controller to idle; no clearing pass.
// Results appear for one cycle each; the receiver cannot stall.
module signed_binary_to_decimal_ascii (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [sb2dec_pkg::ValueW-1:0]     value_i,
  output logic                              valid_o,
  output logic [sb2dec_pkg::CharW-1:0]      char_code_o,
  output logic                              last_char_o
);
  import sb2dec_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sb2dec_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .valid_o(valid_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  sb2dec_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .value_i    (value_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

endmodule
